/* design/afs_pkg.sv */
// ----------------------------------------------------------------------------
// afs_pkg
// constants and register indexes for the aspect fit with stretch block
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int unsigned SIZE_BITS_DEF = 16;
  localparam int unsigned PCT_BITS      = 8;
  localparam int unsigned STRETCH_RESET = 8;
  localparam int unsigned PERCENT_FULL  = 100;

  typedef enum logic {
    CFG_WIDTH_CAP = 1'b0,
    CFG_STRETCH   = 1'b1
  } cfg_idx_e;

endpackage

/* design/aspect_fit_with_stretch.sv */
// a beat passes stage 0, the product stage, the divider stages, the select stage and the output stage
// throughput: one beat per cycle; a stalled output holds the whole pipeline
// the two divisions are pipelined restoring dividers, one quotient bit per stage
// reset: rst_ni async low clears all valid bits, width_cap to 0, stretch_percent to 8
// ----------------------------------------------------------------------------
// aspect_fit_with_stretch
// fits a source image into a canvas keeping aspect, stretching thin bars away
// ----------------------------------------------------------------------------
module aspect_fit_with_stretch
  import afs_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [SIZE_BITS-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SIZE_BITS-1:0] canvas_width_i,
  input  logic [SIZE_BITS-1:0] canvas_height_i,
  input  logic [SIZE_BITS-1:0] source_width_i,
  input  logic [SIZE_BITS-1:0] source_height_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SIZE_BITS-1:0] fit_width_o,
  output logic [SIZE_BITS-1:0] fit_height_o
);

  localparam int unsigned N  = SIZE_BITS;
  localparam int unsigned N2 = 2 * SIZE_BITS;

  typedef struct packed {
    logic [N2-1:0] n1;
    logic [N2-1:0] n2;
    logic [N-1:0]  r1;
    logic [N-1:0]  r2;
    logic [N-1:0]  cw;
    logic [N-1:0]  ch;
    logic [N-1:0]  sw;
    logic [N-1:0]  sh;
    logic [N-1:0]  w0;
  } div_t;

  logic [N-1:0]        width_cap_q;
  logic [PCT_BITS-1:0] stretch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cap_q <= '0;
      stretch_q   <= PCT_BITS'(STRETCH_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH_CAP: width_cap_q <= cfg_data_i;
        CFG_STRETCH:   stretch_q   <= cfg_data_i[PCT_BITS-1:0];
        default:       width_cap_q <= width_cap_q;
      endcase
    end
  end

  logic en;
  assign en         = !(out_valid_o && !out_ready_i);
  assign in_ready_o = en;

  // stage 0: normalize and cap
  logic         v0_q;
  logic [N-1:0] cw0_q, ch0_q, sw0_q, sh0_q, w00_q;
  logic [N-1:0] cw_n, ch_n, sw_n, sh_n;

  always_comb begin
    cw_n = (canvas_width_i  == '0) ? N'(1) : canvas_width_i;
    ch_n = (canvas_height_i == '0) ? N'(1) : canvas_height_i;
    sw_n = (source_width_i  == '0) ? N'(1) : source_width_i;
    sh_n = (source_height_i == '0) ? N'(1) : source_height_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cw0_q <= cw_n;
      ch0_q <= ch_n;
      sw0_q <= sw_n;
      sh0_q <= sh_n;
      w00_q <= (width_cap_q != '0 && cw_n > width_cap_q) ? width_cap_q : cw_n;
    end
  end

  // stage 1: products feed the divider pipeline
  div_t dq_q [0:N2];
  logic vd_q [0:N2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q[0] <= 1'b0;
    else if (en) vd_q[0] <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq_q[0].n1 <= N2'(w00_q) * N2'(sh0_q);
      dq_q[0].n2 <= N2'(ch0_q) * N2'(sw0_q);
      dq_q[0].r1 <= '0;
      dq_q[0].r2 <= '0;
      dq_q[0].cw <= cw0_q;
      dq_q[0].ch <= ch0_q;
      dq_q[0].sw <= sw0_q;
      dq_q[0].sh <= sh0_q;
      dq_q[0].w0 <= w00_q;
    end
  end

  for (genvar k = 0; k < N2; k++) begin : g_div
    logic [N:0] t1, t2;
    div_t       nx;
    always_comb begin
      nx = dq_q[k];
      t1 = {dq_q[k].r1, dq_q[k].n1[N2-1]};
      t2 = {dq_q[k].r2, dq_q[k].n2[N2-1]};
      if (t1 >= {1'b0, dq_q[k].sw}) begin
        nx.r1 = N'(t1 - {1'b0, dq_q[k].sw});
        nx.n1 = {dq_q[k].n1[N2-2:0], 1'b1};
      end else begin
        nx.r1 = t1[N-1:0];
        nx.n1 = {dq_q[k].n1[N2-2:0], 1'b0};
      end
      if (t2 >= {1'b0, dq_q[k].sh}) begin
        nx.r2 = N'(t2 - {1'b0, dq_q[k].sh});
        nx.n2 = {dq_q[k].n2[N2-2:0], 1'b1};
      end else begin
        nx.r2 = t2[N-1:0];
        nx.n2 = {dq_q[k].n2[N2-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[k+1] <= 1'b0;
      else if (en) vd_q[k+1] <= vd_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) dq_q[k+1] <= nx;
    end
  end

  // select stage: height limit
  logic         vs_q;
  logic [N-1:0] ws_q, hs_q, cws_q, chs_q;
  logic [N-1:0] w_sel, h_sel;

  always_comb begin
    if (dq_q[N2].n1 > N2'(dq_q[N2].ch)) begin
      w_sel = dq_q[N2].n2[N-1:0];
      h_sel = dq_q[N2].ch;
    end else begin
      w_sel = dq_q[N2].w0;
      h_sel = dq_q[N2].n1[N-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q <= 1'b0;
    else if (en) vs_q <= vd_q[N2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ws_q  <= (w_sel == '0) ? N'(1) : w_sel;
      hs_q  <= (h_sel == '0) ? N'(1) : h_sel;
      cws_q <= dq_q[N2].cw;
      chs_q <= dq_q[N2].ch;
    end
  end

  // output stage: stretch thin bars
  logic                  vo_q;
  logic [N-1:0]          wo_q, ho_q;
  logic [N-1:0]          dw, dh;
  logic [N+PCT_BITS-1:0] lw, rw, lh, rh;
  logic                  sw_ok, sh_ok;

  always_comb begin
    dw    = cws_q - ws_q;
    dh    = chs_q - hs_q;
    lw    = (N+PCT_BITS)'(dw) * (N+PCT_BITS)'(PERCENT_FULL);
    lh    = (N+PCT_BITS)'(dh) * (N+PCT_BITS)'(PERCENT_FULL);
    rw    = (N+PCT_BITS)'(ws_q) * (N+PCT_BITS)'(stretch_q);
    rh    = (N+PCT_BITS)'(hs_q) * (N+PCT_BITS)'(stretch_q);
    sw_ok = (stretch_q != '0) && (cws_q > ws_q) && (lw <= rw);
    sh_ok = (stretch_q != '0) && (chs_q > hs_q) && (lh <= rh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= vs_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wo_q <= sw_ok ? cws_q : ws_q;
      ho_q <= sh_ok ? chs_q : hs_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign fit_width_o  = wo_q;
  assign fit_height_o = ho_q;

`ifndef SYNTH
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fit_width_o != '0 && fit_height_o != '0))
    else $error("zero result size");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_stall_holds_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(vs_q) && (!vs_q || $stable(ws_q))))
    else $error("inner stage moved during stall");
`endif

endmodule

/* bench/tb_aspect_fit_with_stretch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aspect_fit_with_stretch
// drives canvas and source sizes through the aspect fit block, predicts each
// fitted size and compares it with the result beats, across cap and stretch
// settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_aspect_fit_with_stretch;
  import afs_pkg::*;

  localparam int unsigned SB = 16;
  localparam int unsigned LATENCY = 2 * SB + 4;
  localparam longint LIMIT = 600000;

  typedef struct packed {
    logic [SB-1:0] cw;
    logic [SB-1:0] ch;
    logic [SB-1:0] sw;
    logic [SB-1:0] sh;
  } sizes_t;

  typedef struct packed {
    logic [SB-1:0] w;
    logic [SB-1:0] h;
  } fit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_WIDTH_CAP;
  logic [SB-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [SB-1:0] canvas_width_i = '0;
  logic [SB-1:0] canvas_height_i = '0;
  logic [SB-1:0] source_width_i = '0;
  logic [SB-1:0] source_height_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SB-1:0] fit_width_o;
  logic [SB-1:0] fit_height_o;

  aspect_fit_with_stretch #(.SIZE_BITS(SB)) dut (.*);

  always #5 clk_i = ~clk_i;

  sizes_t pending_sizes[$];
  fit_t expected_fits[$];
  logic [SB-1:0] cap_q;
  logic [7:0] pct_q;
  bit quiet_tail = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned mismatches = 0;
  longint cycles = 0;

  function automatic longint unsigned stretch_axis(longint unsigned canvas,
                                                   longint unsigned size,
                                                   longint unsigned pct);
    if (canvas > size && (canvas - size) * 100 <= size * pct) return canvas;
    return size;
  endfunction

  function automatic fit_t fit_size(sizes_t s, logic [SB-1:0] cap, logic [7:0] pct);
    longint unsigned cw, ch, sw, sh, w, h;
    fit_t f;
    cw = (s.cw == 0) ? 64'd1 : 64'(s.cw);
    ch = (s.ch == 0) ? 64'd1 : 64'(s.ch);
    sw = (s.sw == 0) ? 64'd1 : 64'(s.sw);
    sh = (s.sh == 0) ? 64'd1 : 64'(s.sh);
    w = (cap != 0 && cw > 64'(cap)) ? 64'(cap) : cw;
    h = (w * sh) / sw;
    if (h > ch) begin
      h = ch;
      w = (h * sw) / sh;
    end
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (pct != 0) begin
      w = stretch_axis(cw, w, 64'(pct));
      h = stretch_axis(ch, h, 64'(pct));
    end
    f.w = w[SB-1:0];
    f.h = h[SB-1:0];
    return f;
  endfunction

  function automatic logic [SB-1:0] rand_size();
    case ($urandom_range(0, 5))
      0: return SB'($urandom_range(0, 3));
      1: return SB'($urandom_range(0, 65535));
      2: return 16'hffff - SB'($urandom_range(0, 3));
      default: return SB'($urandom_range(1, 2000));
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_fits.push_back(fit_size({canvas_width_i, canvas_height_i,
                                          source_width_i, source_height_i}, cap_q, pct_q));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_sizes.size() > 0) begin
          sizes_t s;
          s = pending_sizes.pop_front();
          {canvas_width_i, canvas_height_i, source_width_i, source_height_i} <= s;
          in_valid_i <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        fit_t e;
        if (expected_fits.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected beat %0d x %0d", fit_width_o, fit_height_o);
        end else begin
          e = expected_fits.pop_front();
          if (e.w !== fit_width_o || e.h !== fit_height_o) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("fit: expected %0d x %0d, got %0d x %0d",
                       e.w, e.h, fit_width_o, fit_height_o);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("aspect_fit_with_stretch: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_sizes.size() > 0 || in_valid_i || expected_fits.size() > 0)
      @(negedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SB-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH_CAP) cap_q = val;
    else pct_q = val[7:0];
    @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_sizes.push_back({rand_size(), rand_size(), rand_size(), rand_size()});
  endtask

  initial begin
    cap_q = '0;
    pct_q = 8'(STRETCH_RESET);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zeros, extremes, tall and wide sources, thin bars
    pending_sizes.push_back({16'd0, 16'd0, 16'd0, 16'd0});
    pending_sizes.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff});
    pending_sizes.push_back({16'hffff, 16'hffff, 16'd1, 16'hffff});
    pending_sizes.push_back({16'hffff, 16'hffff, 16'hffff, 16'd1});
    pending_sizes.push_back({16'd1, 16'hffff, 16'hffff, 16'd1});
    pending_sizes.push_back({16'd100, 16'd100, 16'd100, 16'd93});
    pending_sizes.push_back({16'd100, 16'd100, 16'd93, 16'd100});
    pending_sizes.push_back({16'd100, 16'd100, 16'd100, 16'd91});
    pending_sizes.push_back({16'd640, 16'd480, 16'd1920, 16'd1080});
    pending_sizes.push_back({16'd0, 16'd5, 16'd7, 16'd0});
    pending_sizes.push_back({16'h8000, 16'h7fff, 16'h5555, 16'haaaa});
    queue_random(300);
    wait_drained();
    write_reg(CFG_WIDTH_CAP, 16'd500);
    write_reg(CFG_STRETCH, 16'd0);
    pending_sizes.push_back({16'd400, 16'd300, 16'd4, 16'd3});
    pending_sizes.push_back({16'd1000, 16'd300, 16'd4, 16'd3});
    queue_random(300);
    wait_drained();
    write_reg(CFG_WIDTH_CAP, 16'hffff);
    write_reg(CFG_STRETCH, 16'd255);
    queue_random(300);
    wait_drained();
    write_reg(CFG_WIDTH_CAP, 16'd1);
    write_reg(CFG_STRETCH, 16'd100);
    queue_random(200);
    wait_drained();
    write_reg(CFG_WIDTH_CAP, 16'd0);
    write_reg(CFG_STRETCH, 16'd1);
    queue_random(150);
    while (pending_sizes.size() > 0) @(posedge clk_i);
    quiet_tail = 1'b1;
    queue_random(150);
    wait_drained();
    if (mismatches == 0) $display("aspect_fit_with_stretch: match");
    else $display("aspect_fit_with_stretch: mismatch");
    $finish;
  end

endmodule
